FILE: rtl/core/crcdf_pkg.sv
// Shared types, constants and CRC byte-update functions of the frame deframer.
package crcdf_pkg;

  // Framing constants
  localparam logic [7:0]  START_BYTE    = 8'hA5;
  localparam logic [7:0]  HDR_CRC_INIT  = 8'hFF;
  localparam logic [15:0] FRM_CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] HDR_CRC_POS   = 16'd4;
  localparam logic [7:0]  CRC8_POLY_R   = 8'h8C;
  localparam logic [15:0] CRC16_POLY_R  = 16'h8408;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_CMD     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_TAIL    = 5'b10000
  } phase_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_CRC  = 2'd1,
    ST_FRM_CRC  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // One result item as it leaves the parser
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] command_id;
    logic [15:0] data_length;
    logic [7:0]  sequence_number;
    status_e     status;
  } result_t;

  // Reflected CRC-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/crcdf_if.sv
// Channel interfaces: received bytes, results and the length-limit write port.
interface crcdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcdf_result_if;
  logic        valid;
  logic        ready;
  logic [0:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] command_id;
  logic [15:0] data_length;
  logic [7:0]  sequence_number;
  logic [1:0]  status;
  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output command_id, output data_length, output sequence_number,
                  output status, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input command_id, input data_length, input sequence_number,
                  input status, output ready);
endinterface

interface crcdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload_len;
  modport source (output valid, output max_payload_len, input ready);
  modport sink   (input valid, input max_payload_len, output ready);
endinterface

FILE: rtl/core/crcdf_in_stage.sv
// Input register: holds one received byte until the parser consumes it.
module crcdf_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  crcdf_byte_if.sink    rx_i,
  input  logic          step_i,
  output logic          valid_o,
  output logic [7:0]    byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  // Free slot, or the held byte leaves this cycle
  assign rx_i.ready = !vld_q || step_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (step_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = vld_q;
  assign byte_o  = byte_q;

endmodule

FILE: rtl/core/crcdf_parser.sv
// Frame parser: phase tracking, header/frame CRC update and result forming.
module crcdf_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [15:0]          max_len_i,
  output logic                 emit_o,
  output crcdf_pkg::result_t   res_o
);

  crcdf_pkg::phase_e phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  hcrc_q, hcrc_d;
  logic [15:0] fcrc_q, fcrc_d;
  logic [7:0]  tail_q, tail_d;

  logic [7:0]  hcrc_upd;
  logic [15:0] fcrc_upd;
  logic [15:0] cnt_inc;

  assign hcrc_upd = crcdf_pkg::crc8_step(hcrc_q, byte_i);
  assign fcrc_upd = crcdf_pkg::crc16_step(fcrc_q, byte_i);
  assign cnt_inc  = cnt_q + 16'd1;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    seq_d   = seq_q;
    cmd_d   = cmd_q;
    hcrc_d  = hcrc_q;
    fcrc_d  = fcrc_q;
    tail_d  = tail_q;
    emit_o  = 1'b0;

    res_o.kind            = crcdf_pkg::KIND_VERDICT;
    res_o.payload_byte    = 8'h00;
    res_o.payload_index   = 16'h0000;
    res_o.command_id      = cmd_q;
    res_o.data_length     = len_q;
    res_o.sequence_number = seq_q;
    res_o.status          = crcdf_pkg::ST_OK;

    if (step_i) begin
      case (phase_q)
        crcdf_pkg::PH_HEADER: begin
          fcrc_d = fcrc_upd;
          if (cnt_q < crcdf_pkg::HDR_CRC_POS) begin
            if (cnt_q == 16'd1) begin
              len_d = {8'h00, byte_i};
            end else if (cnt_q == 16'd2) begin
              len_d = {byte_i, len_q[7:0]};
            end else begin
              seq_d = byte_i;
            end
            hcrc_d = hcrc_upd;
            cnt_d  = cnt_inc;
          end else if (byte_i != hcrc_q) begin
            // bad header CRC wins over the length check
            emit_o       = 1'b1;
            res_o.status = crcdf_pkg::ST_HDR_CRC;
            phase_d      = crcdf_pkg::PH_HUNT;
            cnt_d        = 16'd0;
          end else if (len_q > max_len_i) begin
            emit_o       = 1'b1;
            res_o.status = crcdf_pkg::ST_TOO_LONG;
            phase_d      = crcdf_pkg::PH_HUNT;
            cnt_d        = 16'd0;
          end else begin
            phase_d = crcdf_pkg::PH_CMD;
            cnt_d   = 16'd0;
          end
        end
        crcdf_pkg::PH_CMD: begin
          fcrc_d = fcrc_upd;
          if (cnt_q == 16'd0) begin
            cmd_d = {8'h00, byte_i};
            cnt_d = 16'd1;
          end else begin
            cmd_d   = {byte_i, cmd_q[7:0]};
            cnt_d   = 16'd0;
            phase_d = (len_q == 16'd0) ? crcdf_pkg::PH_TAIL : crcdf_pkg::PH_PAYLOAD;
          end
        end
        crcdf_pkg::PH_PAYLOAD: begin
          fcrc_d              = fcrc_upd;
          emit_o              = 1'b1;
          res_o.kind          = crcdf_pkg::KIND_PAYLOAD;
          res_o.payload_byte  = byte_i;
          res_o.payload_index = cnt_q;
          if (cnt_inc >= len_q) begin
            phase_d = crcdf_pkg::PH_TAIL;
            cnt_d   = 16'd0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        crcdf_pkg::PH_TAIL: begin
          if (cnt_q == 16'd0) begin
            tail_d = byte_i;
            cnt_d  = 16'd1;
          end else begin
            emit_o       = 1'b1;
            res_o.status = (tail_q == fcrc_q[7:0] && byte_i == fcrc_q[15:8]) ?
                           crcdf_pkg::ST_OK : crcdf_pkg::ST_FRM_CRC;
            phase_d      = crcdf_pkg::PH_HUNT;
            cnt_d        = 16'd0;
          end
        end
        default: begin
          // hunting, and any unused phase code
          phase_d = crcdf_pkg::PH_HUNT;
          if (byte_i == crcdf_pkg::START_BYTE) begin
            hcrc_d  = crcdf_pkg::crc8_step(crcdf_pkg::HDR_CRC_INIT, byte_i);
            fcrc_d  = crcdf_pkg::crc16_step(crcdf_pkg::FRM_CRC_INIT, byte_i);
            len_d   = 16'd0;
            seq_d   = 8'd0;
            cmd_d   = 16'd0;
            tail_d  = 8'd0;
            cnt_d   = 16'd1;
            phase_d = crcdf_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crcdf_pkg::PH_HUNT;
      cnt_q   <= 16'd0;
      len_q   <= 16'd0;
      seq_q   <= 8'd0;
      cmd_q   <= 16'd0;
      hcrc_q  <= crcdf_pkg::HDR_CRC_INIT;
      fcrc_q  <= crcdf_pkg::FRM_CRC_INIT;
      tail_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
      hcrc_q  <= hcrc_d;
      fcrc_q  <= fcrc_d;
      tail_q  <= tail_d;
    end
  end

endmodule

FILE: rtl/core/crcdf_out_stage.sv
// Result register: holds one result until the downstream side takes it.
module crcdf_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  crcdf_pkg::result_t   res_i,
  output logic                 free_o,
  crcdf_result_if.source       res_o
);

  logic               vld_q, vld_d;
  crcdf_pkg::result_t res_q;

  // Room for a new result when empty or being drained now
  assign free_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid           = vld_q;
  assign res_o.kind            = res_q.kind;
  assign res_o.payload_byte    = res_q.payload_byte;
  assign res_o.payload_index   = res_q.payload_index;
  assign res_o.command_id      = res_q.command_id;
  assign res_o.data_length     = res_q.data_length;
  assign res_o.sequence_number = res_q.sequence_number;
  assign res_o.status          = res_q.status;

endmodule

FILE: rtl/core/crc_checked_frame_deframer.sv
// Top level of the CRC-checked serial frame deframer.
//
//  Channel  Dir  Transaction carries
//  rx_i     in   rx_byte: one received stream byte
//  res_o    out  kind, payload_byte, payload_index, command_id, data_length,
//                sequence_number, status
//  cfg_i    in   max_payload_len (always ready)
//
// One byte per cycle sustained while the result side takes each result; a byte
// goes from its transaction into the input register, then through CRC/phase
// logic into the result register, from which its result transaction is made.
// Reset clears the phase to hunting and the length limit to 512.
// A stalled result register holds the parser; the input register keeps taking
// a byte while a finished result waits, until both registers are full.
module crc_checked_frame_deframer (
  input  logic            clk_i,
  input  logic            rst_ni,
  crcdf_byte_if.sink      rx_i,
  crcdf_result_if.source  res_o,
  crcdf_cfg_if.sink       cfg_i
);

  logic               in_vld;
  logic [7:0]         in_byte;
  logic               out_free;
  logic               step;
  logic               emit;
  crcdf_pkg::result_t res;
  logic [15:0]        max_len_q;

  // Length limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= crcdf_pkg::MAX_LEN_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_payload_len;
    end
  end

  // Parser advances when a byte is held and the result side has room
  assign step = in_vld && out_free;

  crcdf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .step_i  (step),
    .valid_o (in_vld),
    .byte_o  (in_byte)
  );

  crcdf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte),
    .max_len_i (max_len_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  crcdf_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule
